// File: rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
`define CHK_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

// File: rtl/stmc_pkg.sv
package stmc_pkg;
  localparam int VAL_W  = 32;
  localparam int STEP_W = 30;
  localparam int ENT_W  = 42;
  localparam int COST_W = 62;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
  localparam int REG_STEP = 0;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_RD0, S_CHK, S_SD_RD, S_SD_CMP, S_SD_WR,
    S_PUSH, S_SU_RD, S_SU_CMP, S_OUT
  } stmc_state_t;

  typedef struct packed {
    logic start;
    logic mul;
    logic rd_top;
    logic chk;
    logic sd_rd;
    logic sd_cmp;
    logic sd_wr;
    logic push;
    logic su_rd;
    logic su_cmp;
    logic out_load;
  } stmc_cmd_t;

  typedef struct packed {
    logic skip;
    logic replace;
    logic sd_left;
    logic sd_done;
    logic push_drop;
    logic su_top;
    logic su_done;
  } stmc_sts_t;
endpackage

// File: rtl/stmc_stream_if.sv
interface stmc_stream_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/stmc_ctrl.sv
module stmc_ctrl
  import stmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_busy,
  input  stmc_sts_t sts,
  output stmc_cmd_t cmd
);
  stmc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_RD0;
      end
      S_RD0: begin
        cmd.rd_top = 1'b1;
        state_nxt = sts.skip ? S_OUT : S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        state_nxt = sts.replace ? S_SD_RD : S_PUSH;
      end
      S_SD_RD: begin
        cmd.sd_rd = 1'b1;
        state_nxt = S_SD_CMP;
      end
      S_SD_CMP: begin
        cmd.sd_cmp = 1'b1;
        if (sts.sd_left) state_nxt = S_SD_RD;
        else state_nxt = sts.sd_done ? S_PUSH : S_SD_WR;
      end
      S_SD_WR: begin
        cmd.sd_wr = 1'b1;
        state_nxt = S_SD_RD;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        state_nxt = sts.push_drop ? S_OUT : S_SU_RD;
      end
      S_SU_RD: begin
        cmd.su_rd = 1'b1;
        state_nxt = sts.su_top ? S_OUT : S_SU_CMP;
      end
      S_SU_CMP: begin
        cmd.su_cmp = 1'b1;
        state_nxt = sts.su_done ? S_OUT : S_SU_RD;
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// File: rtl/stmc_datapath.sv
module stmc_datapath
  import stmc_pkg::*;
#(
  parameter int MAX_ITEMS  = 1024,
  parameter int HEAP_DEPTH = 2048
)(
  input  logic                     clk,
  input  logic                     rst_n,
  input  stmc_cmd_t                cmd,
  output stmc_sts_t                sts,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic                     in_first,
  input  logic [STEP_W-1:0]        step,
  output logic [COST_W-1:0]        cost,
  output logic                     ovf
);
  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int IW = $clog2(MAX_ITEMS + 1);

  logic signed [ENT_W-1:0] mem [HEAP_DEPTH];
  logic signed [ENT_W-1:0] rd_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;
  logic signed [ENT_W-1:0] wr_data;

  logic [CW-1:0] cnt_r;
  logic [IW-1:0] idx_r;
  logic [COST_W-1:0] cost_r;
  logic ovf_r;
  logic signed [VAL_W-1:0] val_r;
  logic signed [ENT_W-1:0] adj_r, best_r;
  logic [CW:0] pos_r, big_r, kid_r;
  logic kid_sel_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  logic [CW:0] left_w, right_w, parent_w;
  assign left_w  = {pos_r[CW-1:0], 1'b1};
  assign right_w = left_w + 1'b1;
  assign parent_w = (pos_r - 1'b1) >> 1;

  logic [IW+STEP_W-1:0] prod_w;
  assign prod_w = {{STEP_W{1'b0}}, idx_r} * {{IW{1'b0}}, step};

  logic [COST_W-1:0] diff_w, room_w;
  assign diff_w = COST_W'(rd_r - adj_r);
  assign room_w = COST_MAX - cost_r;

  // sift-down: kid_sel_r picks left then right child read
  logic kid_ok, best_upd;
  assign kid_ok = (kid_r < {1'b0, cnt_r});
  assign best_upd = kid_ok && (rd_r > best_r);

  assign sts.skip = (idx_r >= IW'(MAX_ITEMS));
  assign sts.replace = (cnt_r != '0) && (rd_r > adj_r);
  assign sts.sd_left = !kid_sel_r;
  assign sts.sd_done = kid_sel_r && ((best_upd ? kid_r : big_r) == pos_r);
  assign sts.push_drop = (cnt_r >= CW'(HEAP_DEPTH));
  assign sts.su_top = (pos_r == '0);
  assign sts.su_done = (rd_r >= adj_r);

  always_comb begin
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = adj_r;
    if (cmd.sd_rd) rd_addr = AW'(kid_r);
    if (cmd.su_rd) rd_addr = AW'(parent_w);
    if (cmd.chk && sts.replace) begin
      wr_en = 1'b1;
      wr_addr = '0;
    end
    if (cmd.sd_wr) begin
      wr_en = 1'b1;
      wr_addr = AW'(pos_r);
      wr_data = best_r;
    end
    if (cmd.sd_cmp && sts.sd_done) begin
      wr_en = 1'b1;
      wr_addr = AW'(pos_r);
    end
    if (cmd.push && !sts.push_drop) begin
      wr_en = 1'b1;
      wr_addr = AW'(cnt_r);
    end
    if (cmd.su_rd) begin
      wr_en = 1'b1;
      wr_addr = AW'(pos_r);
    end
    if (cmd.su_cmp && !sts.su_done) begin
      wr_en = 1'b1;
      wr_addr = AW'(pos_r);
      wr_data = rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
      cost_r <= '0;
      ovf_r <= 1'b0;
      cost <= '0;
      ovf <= 1'b0;
    end else begin
      if (cmd.start) begin
        val_r <= in_value;
        if (in_first) begin
          cnt_r <= '0;
          idx_r <= '0;
          cost_r <= '0;
          ovf_r <= 1'b0;
        end
      end
      if (cmd.mul)
        adj_r <= ENT_W'(val_r) + ENT_W'(prod_w);
      if (cmd.rd_top) begin
        if (sts.skip) ovf_r <= 1'b1;
        else idx_r <= idx_r + 1'b1;
      end
      if (cmd.chk) begin
        if (sts.replace) begin
          cost_r <= (diff_w > room_w) ? COST_MAX : cost_r + diff_w;
          pos_r <= '0;
          kid_r <= 'd1;
          kid_sel_r <= 1'b0;
          best_r <= adj_r;
          big_r <= '0;
        end
      end
      if (cmd.sd_cmp) begin
        if (best_upd) begin
          best_r <= rd_r;
          big_r <= kid_r;
        end
        if (!kid_sel_r) begin
          kid_sel_r <= 1'b1;
          kid_r <= right_w;
        end
      end
      if (cmd.sd_wr) begin
        pos_r <= big_r;
        kid_r <= {big_r[CW-1:0], 1'b1};
        kid_sel_r <= 1'b0;
        best_r <= adj_r;
      end
      if (cmd.push) begin
        pos_r <= {1'b0, cnt_r};
        if (!sts.push_drop) cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.su_cmp && !sts.su_done) pos_r <= parent_w;
      if (cmd.out_load) begin
        cost <= cost_r;
        ovf <= ovf_r;
      end
    end
  end
endmodule

// File: rtl/slope_trick_monotone_cost_top.sv
// Channel | Dir | Payload
// in_     | in  | value[31:0] signed, first_item
// out_    | out | total_cost[61:0], overflow
// cfg_    | in  | APB, step_offset at 0x0
// One item at a time, through one memory port pair: multiply, read the heap top
// and compare it; a top replacement then sifts down, reading the left and right
// child and writing per level; the insert then sifts up, a read and compare per
// level; then the result is loaded. An ignored item goes straight to the load.
// rst_n is synchronous; heap contents are not cleared.
// A waiting result holds the controller until taken.
module slope_trick_monotone_cost_top
  import stmc_pkg::*;
#(
  parameter int MAX_ITEMS  = 1024,
  parameter int HEAP_DEPTH = 2048
)(
  input  logic          clk,
  input  logic          rst_n,
  stmc_stream_if.sink   in_ch,
  stmc_stream_if.source out_ch,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [1:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);
`include "assert_macros.svh"
  logic [STEP_W-1:0] step_r;
  stmc_cmd_t cmd;
  stmc_sts_t sts;
  logic out_valid_r;
  logic [COST_W-1:0] cost;
  logic ovf;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'(REG_STEP * 4)) ? {2'b0, step_r} : '0;
  always_ff @(posedge clk) begin
    if (!rst_n) step_r <= '0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'(REG_STEP * 4))
      step_r <= cfg_pwdata[STEP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = {cost, ovf};

  stmc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_busy(out_valid_r && !out_ch.ready), .sts(sts), .cmd(cmd)
  );

  stmc_datapath #(.MAX_ITEMS(MAX_ITEMS), .HEAP_DEPTH(HEAP_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_value(in_ch.data[VAL_W:1]), .in_first(in_ch.data[0]),
    .step(step_r), .cost(cost), .ovf(ovf)
  );

  `CHK_IMPL(a_load_free, cmd.out_load, !out_valid_r || out_ch.ready)
  `CHK_NEXT(a_load_shows, cmd.out_load, out_valid_r)
  `CHK_IMPL(a_accept_idle, in_ch.valid && in_ch.ready, !cmd.out_load)
endmodule
